### hw/rtl/g6sd_pkg.sv
package g6sd_pkg;

  // Width of the vertex fields on the result channel.
  localparam int VC_W = 36;

  // Number of adjacency bits carried by one graph6 character.
  localparam int GROUP_W = 6;

  // Entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic {
    OP_COUNT = 1'b0,
    OP_BITS  = 1'b1
  } op_t;

  // One queued command: either a finished vertex count or six adjacency bits.
  typedef struct packed {
    op_t             op;
    logic [VC_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    kind_t           kind;
    logic [VC_W-1:0] vertex_count;
    logic [VC_W-1:0] row_vertex;
    logic [VC_W-1:0] column_vertex;
    logic            last;
  } result_t;

endpackage

### hw/rtl/g6sd_fifo.sv
module g6sd_fifo #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/g6sd_front.sv
module g6sd_front #(
  parameter int VERTEX_BITS = 36
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            start_of_graph,
  output logic            cmd_push,
  output g6sd_pkg::cmd_t  cmd,
  input  logic            cmd_full
);
  import g6sd_pkg::*;

  localparam logic [7:0]      COUNT_MARK = 8'h7e;
  localparam logic [7:0]      CHAR_BIAS  = 8'd63;
  localparam logic [VC_W-1:0] CNT_MASK   = {VC_W{1'b1}} >> (VC_W - VERTEX_BITS);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_GROUPS,
    PH_EDGES
  } phase_t;

  phase_t            phase;
  phase_t            cur_phase;
  phase_t            phase_next;
  logic [2:0]        left;
  logic [2:0]        left_next;
  logic [VC_W-1:0]   acc;
  logic [VC_W-1:0]   acc_base;
  logic [VC_W-1:0]   acc_next;
  logic [7:0]        biased;
  logic [GROUP_W-1:0] group;
  logic              push;
  logic              accept;

  assign in_ready = !cmd_full;
  assign accept   = in_valid && !cmd_full;
  assign biased   = data_byte - CHAR_BIAS;
  assign group    = biased[GROUP_W-1:0];

  always_comb begin
    // A start flag drops whatever the previous string left behind.
    cur_phase  = start_of_graph ? PH_FIRST : phase;
    left_next  = start_of_graph ? 3'd0 : left;
    acc_base   = start_of_graph ? '0 : acc;
    acc_next   = acc_base;
    phase_next = cur_phase;
    push       = 1'b0;
    cmd.op     = OP_COUNT;
    cmd.value  = '0;
    unique case (cur_phase)
      PH_FIRST: begin
        if (data_byte == COUNT_MARK) begin
          phase_next = PH_SECOND;
        end else begin
          acc_next   = VC_W'(group);
          push       = 1'b1;
          phase_next = PH_EDGES;
        end
      end
      PH_SECOND: begin
        if (data_byte == COUNT_MARK) begin
          acc_next  = '0;
          left_next = 3'd6;
        end else begin
          acc_next  = VC_W'(group);
          left_next = 3'd2;
        end
        phase_next = PH_GROUPS;
      end
      PH_GROUPS: begin
        acc_next = {acc_base[VC_W-GROUP_W-1:0], group};
        if (left_next != 3'd0) begin
          left_next = left_next - 3'd1;
        end
        if (left_next == 3'd0) begin
          push       = 1'b1;
          phase_next = PH_EDGES;
        end
      end
      PH_EDGES: begin
        push = 1'b1;
      end
      default: begin
        phase_next = PH_FIRST;
      end
    endcase
    if (cur_phase == PH_EDGES) begin
      cmd.op    = OP_BITS;
      cmd.value = VC_W'(group);
    end else begin
      cmd.value = acc_next & CNT_MASK;
    end
  end

  assign cmd_push = accept && push;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      left  <= 3'd0;
      acc   <= '0;
    end else if (accept) begin
      phase <= phase_next;
      left  <= left_next;
      acc   <= acc_next;
    end
  end

endmodule

### hw/rtl/g6sd_back.sv
module g6sd_back #(
  parameter int VERTEX_BITS = 36
) (
  input  logic              clk,
  input  logic              rst,
  input  g6sd_pkg::cmd_t    cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  output g6sd_pkg::result_t out_item,
  output logic              out_valid,
  input  logic              out_ready
);
  import g6sd_pkg::*;

  localparam int VB = VERTEX_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t             state;
  state_t             state_next;
  state_t             state_after;
  logic [VB-1:0]      n;
  logic [VB-1:0]      col;
  logic [VB-1:0]      row;
  logic [GROUP_W-1:0] bits;
  logic [2:0]         bit_cnt;
  logic               done;
  logic               done_eff;
  result_t            hold;
  logic               hold_valid;
  result_t            res;
  logic               new_res;
  logic               byte_end;
  logic               out_free;
  logic               stall;
  logic               move_h;
  logic [VB:0]        row_inc;
  logic [VB:0]        col_inc;
  logic               wrap;
  logic               finishing;

  assign row_inc   = {1'b0, row} + 1'b1;
  assign col_inc   = {1'b0, col} + 1'b1;
  assign wrap      = (row_inc >= {1'b0, col});
  assign finishing = wrap && (col_inc >= {1'b0, n});

  always_comb begin
    state_next        = state;
    new_res           = 1'b0;
    byte_end          = 1'b0;
    res.kind          = KIND_COUNT;
    res.vertex_count  = VC_W'(n);
    res.row_vertex    = '0;
    res.column_vertex = '0;
    res.last          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        state_next = ST_IDLE;
      end
      ST_COUNT: begin
        new_res = 1'b1;
        if (n <= VB'(1)) begin
          state_next = ST_FINISH;
        end else begin
          byte_end   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        new_res           = bits[GROUP_W-1];
        res.kind          = KIND_EDGE;
        res.row_vertex    = VC_W'(row);
        res.column_vertex = VC_W'(col);
        if (finishing) begin
          state_next = ST_FINISH;
        end else if (bit_cnt == 3'(GROUP_W - 1)) begin
          byte_end   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FINISH: begin
        new_res    = 1'b1;
        res.kind   = KIND_DONE;
        byte_end   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    res.last = byte_end;
  end

  // The hold stage keeps one result back until it is known whether it ends its byte.
  assign out_free = !out_valid || out_ready;
  assign stall    = new_res && hold_valid && !out_free;
  assign move_h   = hold_valid && (hold.last || new_res) && out_free;
  assign cmd_pop  = cmd_valid && !stall && (state_next == ST_IDLE);

  always_comb begin
    done_eff = done;
    if (state == ST_FINISH) begin
      done_eff = 1'b1;
    end else if (state == ST_COUNT) begin
      done_eff = 1'b0;
    end
  end

  // A popped request picks the next state; bits that arrive after completion are dropped.
  always_comb begin
    state_after = state_next;
    if (cmd_pop) begin
      if (cmd.op == OP_COUNT) begin
        state_after = ST_COUNT;
      end else if (!done_eff) begin
        state_after = ST_WALK;
      end else begin
        state_after = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      bit_cnt    <= 3'd0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!stall) begin
        state <= state_after;
        done  <= done_eff;
        if (state == ST_COUNT) begin
          col <= VB'(1);
          row <= '0;
        end else if (state == ST_WALK) begin
          if (wrap) begin
            row <= '0;
            col <= col_inc[VB-1:0];
          end else begin
            row <= row_inc[VB-1:0];
          end
        end
        if (cmd_pop && (cmd.op == OP_BITS) && !done_eff) begin
          bits    <= cmd.value[GROUP_W-1:0];
          bit_cnt <= 3'd0;
        end else if (state == ST_WALK) begin
          bits    <= {bits[GROUP_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + 3'd1;
        end
        if (cmd_pop && (cmd.op == OP_COUNT)) begin
          n <= cmd.value[VB-1:0];
        end
      end

      if (move_h) begin
        out_item  <= hold;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (!stall && new_res) begin
        hold       <= res;
        hold_valid <= 1'b1;
      end else begin
        if (byte_end && hold_valid && !new_res) begin
          hold.last <= 1'b1;
        end
        if (move_h) begin
          hold_valid <= 1'b0;
        end
      end
    end
  end

endmodule

### hw/rtl/graph6_stream_decoder.sv
// Channel | Dir | tdata (low bit first)                         | tuser          | tlast
// s       | in  | data_byte[7:0]                                | start_of_graph | -
// m       | out | vertex_count, row_vertex, column_vertex, pad  | kind[1:0]      | last_of_run
//
// An adjacency byte steps the edge walker through its bits, six at most and fewer when
// the last pair falls inside it, then a completion step when the graph completes. A
// count byte that finishes the count takes a count step, plus a completion step when
// there are no vertex pairs; other count bytes end in the front stage, and bytes after
// completion are dropped. A four-entry request queue sits between the stages and s_tready
// drops while it is full; a hold stage and output register ride out sink stalls.
// Reset is synchronous; there is no clearing pass, so requests are taken right away.
module graph6_stream_decoder #(
  parameter int VERTEX_BITS = 36
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte[7:0]
  input  logic         s_tuser,   // start_of_graph
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // vertex_count[35:0], row_vertex[71:36],
                                  // column_vertex[107:72], zero pad[111:108]
  output logic [1:0]   m_tuser,   // kind[1:0]
  output logic         m_tlast    // last_of_run
);
  import g6sd_pkg::*;

  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    push;
  logic    q_full;
  logic    q_empty;
  logic    pop;
  result_t out_item;

  // The front stage decodes the vertex count and turns each later byte into a
  // request carrying its six adjacency bits.
  g6sd_front #(
    .VERTEX_BITS(VERTEX_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .data_byte     (s_tdata),
    .start_of_graph(s_tuser),
    .cmd_push      (push),
    .cmd           (push_cmd),
    .cmd_full      (q_full)
  );

  g6sd_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(push_cmd),
    .full   (q_full),
    .rd_en  (pop),
    .rd_data(head_cmd),
    .empty  (q_empty)
  );

  // The back stage walks the upper triangle and emits count, edge and completion
  // results, at most one per cycle while the sink does not stall it.
  g6sd_back #(
    .VERTEX_BITS(VERTEX_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (head_cmd),
    .cmd_valid(!q_empty),
    .cmd_pop  (pop),
    .out_item (out_item),
    .out_valid(m_tvalid),
    .out_ready(m_tready)
  );

  assign m_tdata = {4'b0000, out_item.column_vertex, out_item.row_vertex,
                    out_item.vertex_count};
  assign m_tuser = out_item.kind;
  assign m_tlast = out_item.last;

`ifndef SYNTHESIS
  // Completion is always the final result of the byte that causes it.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_DONE)) |-> m_tlast)
    else $error("completion result without last_of_run");

  // An edge always has its smaller endpoint first.
  a_edge_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_EDGE)) |-> (m_tdata[35+36:36] < m_tdata[107:72]))
    else $error("edge endpoints out of order");

  // The column of an edge never reaches the vertex count.
  a_edge_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_EDGE)) |-> (m_tdata[107:72] < m_tdata[35:0]))
    else $error("edge column beyond vertex count");

  // Nothing is offered in the cycle after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result offered right after reset");
`endif

endmodule
